// ===== design/bsc_pkg.sv =====
package bsc_pkg;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        OP_ENCODE = 2'd0,
        OP_DECODE = 2'd1,
        OP_FORCE  = 2'd2,
        OP_NONE   = 2'd3
    } bsc_op_t;

    // Shift codes and fixed values of the code.
    localparam logic [4:0] SHIFT_LETTERS_CODE = 5'd31;
    localparam logic [4:0] SHIFT_FIGURES_CODE = 5'd27;
    localparam logic [4:0] SPACE_CODE         = 5'h04;
    localparam logic [7:0] CASE_OFFSET        = 8'd32;
    localparam logic [7:0] FIRST_PRINTABLE    = 8'd32;
    localparam logic [7:0] DELETE_CHAR        = 8'd127;
    localparam int         CODE_COUNT         = 32;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] character;
        logic [4:0] code_word;
        logic       forced_shift;
    } bsc_in_t;

    typedef struct packed {
        logic [6:0] out_value;
        logic       is_last;
        logic       shift_now;
    } bsc_out_t;

    // One queued job: an optional shift code followed by one value.
    typedef struct packed {
        logic       two;
        logic [6:0] value;
        logic       shift;
    } bsc_job_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } bsc_lookup_t;

    // Character shown by each code in the letters set; zero means none.
    function automatic logic [6:0] letter_char(input logic [4:0] code);
        logic [6:0] ch;
        case (code)
            5'd1:    ch = 7'h45;
            5'd2:    ch = 7'h0A;
            5'd3:    ch = 7'h41;
            5'd4:    ch = 7'h20;
            5'd5:    ch = 7'h53;
            5'd6:    ch = 7'h49;
            5'd7:    ch = 7'h55;
            5'd8:    ch = 7'h0D;
            5'd9:    ch = 7'h44;
            5'd10:   ch = 7'h52;
            5'd11:   ch = 7'h4A;
            5'd12:   ch = 7'h4E;
            5'd13:   ch = 7'h46;
            5'd14:   ch = 7'h43;
            5'd15:   ch = 7'h4B;
            5'd16:   ch = 7'h54;
            5'd17:   ch = 7'h5A;
            5'd18:   ch = 7'h4C;
            5'd19:   ch = 7'h57;
            5'd20:   ch = 7'h48;
            5'd21:   ch = 7'h59;
            5'd22:   ch = 7'h50;
            5'd23:   ch = 7'h51;
            5'd24:   ch = 7'h4F;
            5'd25:   ch = 7'h42;
            5'd26:   ch = 7'h47;
            5'd28:   ch = 7'h4D;
            5'd29:   ch = 7'h58;
            5'd30:   ch = 7'h56;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // Character shown by each code in the figures set; zero means none.
    function automatic logic [6:0] figure_char(input logic [4:0] code);
        logic [6:0] ch;
        case (code)
            5'd1:    ch = 7'h33;
            5'd2:    ch = 7'h0A;
            5'd3:    ch = 7'h2D;
            5'd4:    ch = 7'h20;
            5'd5:    ch = 7'h27;
            5'd6:    ch = 7'h38;
            5'd7:    ch = 7'h37;
            5'd8:    ch = 7'h0D;
            5'd9:    ch = 7'h05;
            5'd10:   ch = 7'h34;
            5'd11:   ch = 7'h07;
            5'd12:   ch = 7'h2C;
            5'd13:   ch = 7'h21;
            5'd14:   ch = 7'h3A;
            5'd15:   ch = 7'h28;
            5'd16:   ch = 7'h35;
            5'd17:   ch = 7'h22;
            5'd18:   ch = 7'h29;
            5'd19:   ch = 7'h32;
            5'd20:   ch = 7'h23;
            5'd21:   ch = 7'h36;
            5'd22:   ch = 7'h30;
            5'd23:   ch = 7'h31;
            5'd24:   ch = 7'h39;
            5'd25:   ch = 7'h3F;
            5'd26:   ch = 7'h26;
            5'd28:   ch = 7'h2E;
            5'd29:   ch = 7'h2F;
            5'd30:   ch = 7'h3B;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // Letters-path code of an upper-case letter or space.
    function automatic bsc_lookup_t letter_code(input logic [7:0] up);
        bsc_lookup_t res;
        logic        allowed;
        res     = '0;
        allowed = ((up >= 8'h41) && (up <= 8'h5A)) || (up == 8'h20);
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (allowed && ({1'b0, letter_char(5'(i))} == up)) begin
                res.hit  = 1'b1;
                res.code = 5'(i);
            end
        end
        return res;
    endfunction

    // Figures-path code of a printable character.
    function automatic bsc_lookup_t figure_code(input logic [7:0] c);
        bsc_lookup_t res;
        logic        allowed;
        res     = '0;
        allowed = (c >= FIRST_PRINTABLE) && (c < DELETE_CHAR);
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (allowed && ({1'b0, figure_char(5'(i))} == c)) begin
                res.hit  = 1'b1;
                res.code = 5'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== design/bsc_front.sv =====
module bsc_front
    import bsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  bsc_in_t  req,
    output logic     push,
    output bsc_job_t job
);

    logic        shift_reg;
    logic        shift_next;
    logic [7:0]  upper;
    bsc_lookup_t let_hit;
    bsc_lookup_t fig_hit;
    logic [6:0]  dec_char;

    // Fold lower case onto upper case and look the character up in both sets.
    always_comb begin
        upper = req.character;
        if ((req.character >= 8'h61) && (req.character <= 8'h7A)) begin
            upper = req.character - CASE_OFFSET;
        end
        let_hit  = letter_code(upper);
        fig_hit  = figure_code(req.character);
        dec_char = shift_reg ? figure_char(req.code_word) : letter_char(req.code_word);
    end

    // Classify the request into a queued job and the next shift state.
    always_comb begin
        shift_next = shift_reg;
        push       = 1'b0;
        job        = '0;
        unique case (bsc_op_t'(req.operation))
            OP_ENCODE: begin
                if (let_hit.hit) begin
                    push       = 1'b1;
                    job.two    = shift_reg;
                    job.value  = {2'b00, let_hit.code};
                    job.shift  = 1'b0;
                    shift_next = 1'b0;
                end else if (fig_hit.hit) begin
                    push       = 1'b1;
                    job.two    = ~shift_reg;
                    job.value  = {2'b00, fig_hit.code};
                    job.shift  = 1'b1;
                    shift_next = 1'b1;
                end
            end
            OP_DECODE: begin
                if (req.code_word == SHIFT_LETTERS_CODE) begin
                    shift_next = 1'b0;
                end else if (req.code_word == SHIFT_FIGURES_CODE) begin
                    shift_next = 1'b1;
                end else if (dec_char != 7'h00) begin
                    push      = 1'b1;
                    job.two   = 1'b0;
                    job.value = dec_char;
                    job.shift = shift_reg;
                end
            end
            OP_FORCE: begin
                shift_next = req.forced_shift;
            end
            default: begin
                shift_next = shift_reg;
            end
        endcase
        push = push & accept;
    end

    // The shift state moves once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else if (accept) begin
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== design/bsc_queue.sv =====
module bsc_queue
    import bsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bsc_job_t push_job,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output bsc_job_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    bsc_job_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Job storage, written at the tail.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/bsc_back.sv =====
module bsc_back
    import bsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     head_valid,
    input  bsc_job_t head,
    output logic     pop,
    output logic     m_valid,
    input  logic     m_ready,
    output bsc_out_t m_data
);

    logic     m_valid_reg;
    bsc_out_t m_data_reg;
    logic     phase_reg;
    logic     out_free;
    logic     load;
    logic     emit_shift;
    logic [4:0] shift_code;

    assign out_free   = !m_valid_reg || m_ready;
    assign load       = out_free && head_valid;
    assign emit_shift = head.two && !phase_reg;
    assign pop        = load && !emit_shift;
    assign shift_code = head.shift ? SHIFT_FIGURES_CODE : SHIFT_LETTERS_CODE;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Output register control and the two-result phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= head_valid;
            end
            if (load) begin
                phase_reg <= emit_shift;
            end
        end
    end

    // Output payload: the shift code first where a job needs one.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.shift_now <= head.shift;
            if (emit_shift) begin
                m_data_reg.out_value <= {2'b00, shift_code};
                m_data_reg.is_last   <= 1'b0;
            end else begin
                m_data_reg.out_value <= head.value;
                m_data_reg.is_last   <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    // A half-done job must still sit at the head of the queue.
    a_phase_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid)
        else $error("second result pending with empty queue");

    // Only a shift code matching the new state may be a non-final result.
    a_shift_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.is_last) |->
        ((m_data_reg.out_value == {2'b00, SHIFT_LETTERS_CODE} && !m_data_reg.shift_now) ||
         (m_data_reg.out_value == {2'b00, SHIFT_FIGURES_CODE} && m_data_reg.shift_now)))
        else $error("non-final result is not a proper shift code");

    // Issuing a shift code leaves the job's value pending.
    a_phase_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && emit_shift) |=> (phase_reg && m_valid_reg && !m_data_reg.is_last))
        else $error("shift code issued without pending value");
`endif

endmodule

// ===== design/baudot_shift_codec.sv =====
// ITA2 Baudot codec with a letters/figures shift state. Each request encodes
// one ASCII character, decodes one five-bit code or forces the shift state.
// A request is taken on every clock while the job queue (QUEUE_DEPTH jobs)
// has room; the shift state is updated as the request is taken, so requests
// may follow one another back to back. The result port sends one result per
// clock while m_ready allows: an encode that changes shift gives two results
// (shift code, then the character code), other encodes and non-silent decodes
// give one, and shift codes, NUL, uncodable characters and forced shifts give
// none. The sustained rate is therefore set by the result port. An idle codec
// passes a request through the job queue and then the output register before
// it presents the first result on m_valid.
module baudot_shift_codec
    import bsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bsc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bsc_out_t m_data
);

    logic     accept;
    logic     push;
    bsc_job_t push_job;
    logic     pop;
    logic     full;
    logic     not_empty;
    bsc_job_t head;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    // Front end: classify requests and track the shift state.
    bsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_data),
        .push    (push),
        .job     (push_job)
    );

    // Job queue between front and back.
    bsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    // Back end: emit the results of each job.
    bsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import bsc_pkg::*;

    // Marks a directed row whose results come from the codec model below.
    localparam int       PREDICTED = -1;
    localparam bsc_out_t NO_RESULT = '0;

    // Character shown by each code in the letters and figures sets; zero means none.
    localparam logic [6:0] LETTER_SET [32] = '{
        7'h00, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49, 7'h55,
        7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43, 7'h4B,
        7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50, 7'h51,
        7'h4F, 7'h42, 7'h47, 7'h00, 7'h4D, 7'h58, 7'h56, 7'h00
    };
    localparam logic [6:0] FIGURE_SET [32] = '{
        7'h00, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h27, 7'h38, 7'h37,
        7'h0D, 7'h05, 7'h34, 7'h07, 7'h2C, 7'h21, 7'h3A, 7'h28,
        7'h35, 7'h22, 7'h29, 7'h32, 7'h23, 7'h36, 7'h30, 7'h31,
        7'h39, 7'h3F, 7'h26, 7'h00, 7'h2E, 7'h2F, 7'h3B, 7'h00
    };

    // Ways in which the receiver holds off results.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_THREE_IN_FOUR,
        READY_ONE_IN_FIVE
    } ready_mode_t;

    // One directed request, with its results typed in where they are obvious.
    typedef struct packed {
        bsc_in_t    req;
        logic       typed;
        logic [1:0] n_typed;
        bsc_out_t   first;
        bsc_out_t   second;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bsc_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    bsc_out_t    m_data;

    logic          shift_figs;
    bsc_out_t      awaited_outputs[$];
    directed_row_t directed_rows[$];
    bsc_out_t      want_output;
    int            error_count;
    int            burst_left;
    int            stall_cycle;
    ready_mode_t   ready_mode;

    baudot_shift_codec i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 2 ns period.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Returns the code of a character in one of the two sets, or -1.
    function automatic int find_code(input logic [7:0] ch, input logic figs);
        for (int i = 0; i < CODE_COUNT; i++) begin
            if ({1'b0, (figs ? FIGURE_SET[i] : LETTER_SET[i])} == ch) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Works out the results of one request and advances the shift state.
    function automatic int ita2_codec_step(input bsc_in_t req, output bsc_out_t res0,
                                           output bsc_out_t res1);
        logic [7:0] up;
        logic [6:0] shown;
        int         code;
        int         count;
        bsc_out_t   char_out;
        count = 0;
        code  = -1;
        res0  = '0;
        res1  = '0;
        case (bsc_op_t'(req.operation))
            OP_ENCODE: begin
                up = req.character;
                if (up >= 8'h61 && up <= 8'h7A) begin
                    up = up - CASE_OFFSET;
                end
                // Letters and space go on the letters path, printable figures otherwise.
                if ((up >= 8'h41 && up <= 8'h5A) || up == 8'h20) begin
                    code = find_code(up, 1'b0);
                    if (shift_figs) begin
                        shift_figs = 1'b0;
                        res0  = bsc_out_t'{{2'b00, SHIFT_LETTERS_CODE}, 1'b0, 1'b0};
                        count = 1;
                    end
                end else if (req.character >= FIRST_PRINTABLE &&
                             req.character < DELETE_CHAR) begin
                    code = find_code(req.character, 1'b1);
                    if (code >= 0 && !shift_figs) begin
                        shift_figs = 1'b1;
                        res0  = bsc_out_t'{{2'b00, SHIFT_FIGURES_CODE}, 1'b0, 1'b1};
                        count = 1;
                    end
                end
                if (code >= 0) begin
                    char_out = bsc_out_t'{7'(code), 1'b1, shift_figs};
                    if (count == 0) begin
                        res0 = char_out;
                    end else begin
                        res1 = char_out;
                    end
                    count++;
                end
            end
            OP_DECODE: begin
                // Shift codes change the state silently; NUL shows nothing.
                if (req.code_word == SHIFT_LETTERS_CODE) begin
                    shift_figs = 1'b0;
                end else if (req.code_word == SHIFT_FIGURES_CODE) begin
                    shift_figs = 1'b1;
                end else begin
                    shown = shift_figs ? FIGURE_SET[req.code_word] : LETTER_SET[req.code_word];
                    if (shown != 7'h00) begin
                        res0  = bsc_out_t'{shown, 1'b1, shift_figs};
                        count = 1;
                    end
                end
            end
            OP_FORCE: begin
                shift_figs = req.forced_shift;
            end
            default: begin
            end
        endcase
        return count;
    endfunction

    // Picks a character: mostly codable ones, folded to lower case at times.
    function automatic logic [7:0] pick_character();
        logic [6:0] ch;
        int         sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            ch = LETTER_SET[$urandom_range(0, 31)];
            if (ch >= 7'h41 && ch <= 7'h5A && $urandom_range(0, 1) == 1) begin
                ch = ch + CASE_OFFSET[6:0];
            end
            return {1'b0, ch};
        end else if (sel < 7) begin
            return {1'b0, FIGURE_SET[$urandom_range(0, 31)]};
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_row(input bsc_op_t op, input logic [7:0] ch, input logic [4:0] cw,
                           input logic fs, input int n_typed, input bsc_out_t first,
                           input bsc_out_t second);
        directed_row_t row;
        row.req     = bsc_in_t'{op, ch, cw, fs};
        row.typed   = (n_typed != PREDICTED);
        row.n_typed = (n_typed == PREDICTED) ? 2'd0 : 2'(n_typed);
        row.first   = first;
        row.second  = second;
        directed_rows.push_back(row);
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Presents one request, waits for it to be taken and records its results.
    task automatic issue_request(input bsc_in_t req, input logic typed,
                                 input logic [1:0] n_typed, input bsc_out_t first,
                                 input bsc_out_t second);
        bsc_out_t pred0;
        bsc_out_t pred1;
        int       n_pred;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_pred = ita2_codec_step(req, pred0, pred1);
        if (typed) begin
            if (n_typed > 0) awaited_outputs.push_back(first);
            if (n_typed > 1) awaited_outputs.push_back(second);
        end else begin
            if (n_pred > 0) awaited_outputs.push_back(pred0);
            if (n_pred > 1) awaited_outputs.push_back(pred1);
        end
        pace_sender();
    endtask

    // Holds the sender back until every awaited result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: a stall pattern that is drawn anew at random from the ready modes.
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS:        m_ready <= 1'b1;
            READY_RANDOM:        m_ready <= 1'($urandom_range(0, 1));
            READY_THREE_IN_FOUR: m_ready <= (stall_cycle % 4 != 0);
            default:             m_ready <= (stall_cycle % 5 == 0);
        endcase
    end

    // Result checker: each result against the oldest awaited one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_outputs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                error_count++;
            end else begin
                want_output = awaited_outputs.pop_front();
                if (m_data.out_value !== want_output.out_value) begin
                    $display("%0t: out_value expected %h, actual %h", $time,
                             want_output.out_value, m_data.out_value);
                    error_count++;
                end
                if (m_data.is_last !== want_output.is_last) begin
                    $display("%0t: is_last expected %b, actual %b", $time,
                             want_output.is_last, m_data.is_last);
                    error_count++;
                end
                if (m_data.shift_now !== want_output.shift_now) begin
                    $display("%0t: shift_now expected %b, actual %b", $time,
                             want_output.shift_now, m_data.shift_now);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random requests, then the verdict.
    initial begin
        bsc_in_t rq;
        int      sel;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        ready_mode  = READY_ALWAYS;
        stall_cycle = 0;
        error_count = 0;
        burst_left  = 0;
        shift_figs  = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Encoding from letters: upper and lower case, space, then a figure.
        add_row(OP_ENCODE, 8'h41, 5'd0, 1'b0, 1, bsc_out_t'{7'd3, 1'b1, 1'b0}, NO_RESULT);
        add_row(OP_ENCODE, 8'h61, 5'd0, 1'b0, 1, bsc_out_t'{7'd3, 1'b1, 1'b0}, NO_RESULT);
        add_row(OP_ENCODE, 8'h20, 5'd0, 1'b0, 1, bsc_out_t'{7'd4, 1'b1, 1'b0}, NO_RESULT);
        add_row(OP_ENCODE, 8'h33, 5'd0, 1'b0, 2, bsc_out_t'{7'd27, 1'b0, 1'b1},
                bsc_out_t'{7'd1, 1'b1, 1'b1});
        add_row(OP_ENCODE, 8'h30, 5'd0, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        // A space while in figures goes back to letters first.
        add_row(OP_ENCODE, 8'h20, 5'd0, 1'b0, 2, bsc_out_t'{7'd31, 1'b0, 1'b0},
                bsc_out_t'{7'd4, 1'b1, 1'b0});
        // Characters with no code give no result; z, ? and Z among them do give results.
        add_row(OP_ENCODE, 8'h00, 5'd0, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'hFF, 5'd31, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h7F, 5'd0, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h7E, 5'd0, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h7A, 5'd0, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h3F, 5'd0, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h5A, 5'd0, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_ENCODE, 8'h80, 5'd0, 1'b0, 0, NO_RESULT, NO_RESULT);
        // Decoding: NUL, silent shifts, WRU, bell and a line feed.
        add_row(OP_DECODE, 8'h00, 5'd0, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd27, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd9, 1'b0, 1, bsc_out_t'{7'h05, 1'b1, 1'b1}, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd11, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd31, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd2, 1'b0, 1, bsc_out_t'{7'h0A, 1'b1, 1'b0}, NO_RESULT);
        // Forcing the shift, then the unused operation with every field set.
        add_row(OP_FORCE, 8'h00, 5'd0, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd4, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_NONE, 8'hFF, 5'd31, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(OP_DECODE, 8'h00, 5'd1, 1'b0, PREDICTED, NO_RESULT, NO_RESULT);
        add_row(OP_FORCE, 8'hFF, 5'd31, 1'b0, 0, NO_RESULT, NO_RESULT);

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].n_typed, directed_rows[i].first,
                          directed_rows[i].second);
        end
        drain_results();

        // Random requests with random content in the unused fields.
        for (int i = 0; i < 500; i++) begin
            rq  = bsc_in_t'(16'($urandom()));
            sel = $urandom_range(0, 19);
            if (sel < 9) begin
                rq.operation = OP_ENCODE;
                rq.character = pick_character();
            end else if (sel < 15) begin
                rq.operation = OP_DECODE;
            end else if (sel < 18) begin
                rq.operation = OP_FORCE;
            end else begin
                rq.operation = OP_NONE;
            end
            issue_request(rq, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
            if (i == 250) begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("baudot_shift_codec test passed");
        end else begin
            $display("baudot_shift_codec test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("baudot_shift_codec test failed");
        $finish;
    end

endmodule
